[rtl/spr_pkg.sv]
// ----------------------------------------------------------------------------
// spr_pkg
// shared types, constants and register codes for the sphere repulsion block
// ----------------------------------------------------------------------------
package spr_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int EPS_RAW      = ((1 << FRAC_BITS) + 5000) / 10000;
	localparam int EPS          = (EPS_RAW == 0) ? 1 : EPS_RAW;
	localparam int QUEUE_AW     = 3;
	localparam int FRONT_STAGES = 5;
	localparam int SQRT_STAGES  = 32;
	localparam int DIV_STAGES   = 31;
	localparam int LATENCY      = FRONT_STAGES + 2 + SQRT_STAGES + 2 + DIV_STAGES + 1;

	localparam logic [30:0] RADIUS_RST = 31'd65536;
	localparam logic [30:0] PUSH_RST   = 31'd6554;

	typedef enum logic [2:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_CENTER_Z = 3'd2,
		REG_RADIUS   = 3'd3,
		REG_PUSH     = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] moved_x;
		logic signed [31:0] moved_y;
		logic signed [31:0] moved_z;
		logic               was_inside;
	} result_t;

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
		logic [30:0]        sphere_radius;
		logic [30:0]        push_distance;
	} cfg_t;

	typedef struct packed {
		logic [2:0][31:0] point;
		logic [2:0][31:0] emag;
		logic [2:0]       eneg;
		logic             in_sphere;
		logic [63:0]      esum;
	} q_item_t;

	typedef struct packed {
		logic [2:0][31:0] point;
		logic [2:0][31:0] emag;
		logic [2:0]       eneg;
		logic             in_sphere;
	} sq_item_t;

	typedef struct packed {
		logic [2:0][31:0] point;
		logic [2:0]       eneg;
		logic             in_sphere;
		logic             lzero;
	} dv_item_t;

	typedef struct packed {
		logic empty;
		logic almost_full;
	} fifo_stat_t;

endpackage

[rtl/sphere_particle_repulsion_top.sv]
// ----------------------------------------------------------------------------
// sphere_particle_repulsion_top
// pushes cloth particles that lie inside a sphere out along their offset
// ----------------------------------------------------------------------------
// One particle per clock is taken while busy is low, and each gives one result
// after its start transaction; the result is shown for one cycle on result
// with result_valid and cannot be held off. Results pass the 32-stage square
// root and the 31-stage divider lanes behind a short queue. busy stays low in
// normal streaming. The user must write registers through cfg_* only while no
// particle is in flight; the block itself does not enforce this.
module sphere_particle_repulsion_top #(
	parameter int QUEUE_AW = spr_pkg::QUEUE_AW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  spr_pkg::in_item_t item,
	output logic             result_valid,
	output spr_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_data
);
	import spr_pkg::*;

	cfg_t       cfg_q;
	fifo_stat_t stat;
	logic       push, rd_valid;
	q_item_t    push_item, rd_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x      <= '0;
			cfg_q.center_y      <= '0;
			cfg_q.center_z      <= '0;
			cfg_q.sphere_radius <= RADIUS_RST;
			cfg_q.push_distance <= PUSH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CENTER_X: cfg_q.center_x      <= cfg_data;
				REG_CENTER_Y: cfg_q.center_y      <= cfg_data;
				REG_CENTER_Z: cfg_q.center_z      <= cfg_data;
				REG_RADIUS:   cfg_q.sphere_radius <= cfg_data[30:0];
				REG_PUSH:     cfg_q.push_distance <= cfg_data[30:0];
				default:      cfg_q               <= cfg_q;
			endcase
		end
	end

	spr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.cfg      (cfg_q),
		.stat     (stat),
		.push     (push),
		.push_item(push_item)
	);

	spr_fifo #(.AW(QUEUE_AW)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.rd_valid (rd_valid),
		.rd_item  (rd_item),
		.stat     (stat)
	);

	spr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_valid     (rd_valid),
		.rd_item      (rd_item),
		.push_distance(cfg_q.push_distance),
		.result_valid (result_valid),
		.result       (result)
	);

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy, LATENCY))
		else $error("result without matching transaction");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("back end fell behind");

endmodule

[rtl/spr_front.sv]
// ----------------------------------------------------------------------------
// spr_front
// accepts particles, forms offsets and squared lengths, classifies inside
// ----------------------------------------------------------------------------
module spr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  spr_pkg::in_item_t item,
	input  spr_pkg::cfg_t     cfg,
	input  spr_pkg::fifo_stat_t stat,
	output logic              push,
	output spr_pkg::q_item_t  push_item
);
	import spr_pkg::*;

	logic accept;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic signed [31:0] pt [3];
	logic signed [31:0] ct [3];
	logic signed [33:0] d_s1 [3];
	logic signed [33:0] e_s1 [3];
	logic [2:0][31:0] p_s1, p_s2, p_s3, p_s4, p_s5;
	logic [33:0] dabs [3];
	logic [33:0] eabs [3];
	logic        box_c;
	logic [30:0] dmag_s2 [3];
	logic [2:0][31:0] emag_s2, emag_s3, emag_s4, emag_s5;
	logic [2:0] eneg_s2, eneg_s3, eneg_s4, eneg_s5;
	logic box_s2, box_s3, box_s4;
	logic [61:0] dsq_s3 [3];
	logic [63:0] esq_s3 [3];
	logic [61:0] r2_s3, r2_s4;
	logic [63:0] dsum_s4, esum_s4, esum_s5;
	logic inside_s5;

	assign accept = start && !busy;
	assign busy   = stat.almost_full;
	assign pt[0] = item.point_x;
	assign pt[1] = item.point_y;
	assign pt[2] = item.point_z;
	assign ct[0] = cfg.center_x;
	assign ct[1] = cfg.center_y;
	assign ct[2] = cfg.center_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_comb begin
		box_c = 1'b1;
		for (int i = 0; i < 3; i++) begin
			dabs[i] = d_s1[i][33] ? 34'(-d_s1[i]) : 34'(d_s1[i]);
			eabs[i] = e_s1[i][33] ? 34'(-e_s1[i]) : 34'(e_s1[i]);
			if (dabs[i] >= {3'b000, cfg.sphere_radius})
				box_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			d_s1[i]    <= 34'(pt[i]) - 34'(ct[i]);
			e_s1[i]    <= 34'(pt[i]) - 34'(ct[i]) + 34'(EPS);
			p_s1[i]    <= pt[i];
			dmag_s2[i] <= dabs[i][30:0];
			emag_s2[i] <= eabs[i][31:0];
			eneg_s2[i] <= e_s1[i][33];
			dsq_s3[i]  <= dmag_s2[i] * dmag_s2[i];
			esq_s3[i]  <= emag_s2[i] * emag_s2[i];
		end
		box_s2    <= box_c;
		p_s2      <= p_s1;
		r2_s3     <= cfg.sphere_radius * cfg.sphere_radius;
		p_s3      <= p_s2;
		emag_s3   <= emag_s2;
		eneg_s3   <= eneg_s2;
		box_s3    <= box_s2;
		dsum_s4   <= 64'(dsq_s3[0]) + 64'(dsq_s3[1]) + 64'(dsq_s3[2]);
		esum_s4   <= esq_s3[0] + esq_s3[1] + esq_s3[2];
		r2_s4     <= r2_s3;
		p_s4      <= p_s3;
		emag_s4   <= emag_s3;
		eneg_s4   <= eneg_s3;
		box_s4    <= box_s3;
		inside_s5 <= box_s4 && (dsum_s4 < 64'(r2_s4));
		esum_s5   <= esum_s4;
		p_s5      <= p_s4;
		emag_s5   <= emag_s4;
		eneg_s5   <= eneg_s4;
	end

	assign push                = valid_s5;
	assign push_item.point     = p_s5;
	assign push_item.emag      = emag_s5;
	assign push_item.eneg      = eneg_s5;
	assign push_item.in_sphere = inside_s5;
	assign push_item.esum      = esum_s5;

endmodule

[rtl/spr_fifo.sv]
// ----------------------------------------------------------------------------
// spr_fifo
// short queue between the classifying front and the arithmetic back
// ----------------------------------------------------------------------------
module spr_fifo #(
	parameter int AW = spr_pkg::QUEUE_AW
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  spr_pkg::q_item_t    push_item,
	output logic                rd_valid,
	output spr_pkg::q_item_t    rd_item,
	output spr_pkg::fifo_stat_t stat
);
	import spr_pkg::*;

	localparam int DEPTH = 1 << AW;

	q_item_t mem [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   count_q;
	logic          pop;
	logic          rd_valid_q;
	q_item_t       rd_item_q;

	assign pop              = (count_q != '0);
	assign stat.empty       = (count_q == '0);
	assign stat.almost_full = (count_q >= (AW+1)'(DEPTH - FRONT_STAGES));
	assign rd_valid         = rd_valid_q;
	assign rd_item          = rd_item_q;

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_item;
		if (pop)
			rd_item_q <= mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			count_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= pop;
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && (count_q == (AW+1)'(DEPTH)) && !pop))
		else $error("queue overflow");

endmodule

[rtl/spr_isqrt.sv]
// ----------------------------------------------------------------------------
// spr_isqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module spr_isqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [63:0]       in_sq,
	input  spr_pkg::sq_item_t in_item,
	output logic              out_valid,
	output logic [31:0]       out_root,
	output spr_pkg::sq_item_t out_item
);
	import spr_pkg::*;

	logic [63:0] n_a    [1:SQRT_STAGES];
	logic [63:0] root_a [1:SQRT_STAGES];
	logic        vld_a  [1:SQRT_STAGES];
	sq_item_t    item_a [1:SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		localparam logic [63:0] BIT = 64'(1) << (62 - 2*k);
		logic [63:0] n_in, root_in, trial;
		logic        v_in;
		sq_item_t    it_in;
		if (k == 0) begin : g_first
			assign n_in    = in_sq;
			assign root_in = '0;
			assign v_in    = in_valid;
			assign it_in   = in_item;
		end else begin : g_next
			assign n_in    = n_a[k];
			assign root_in = root_a[k];
			assign v_in    = vld_a[k];
			assign it_in   = item_a[k];
		end
		assign trial = root_in + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_a[k+1] <= 1'b0;
			else
				vld_a[k+1] <= v_in;
		end

		always_ff @(posedge clk) begin
			item_a[k+1] <= it_in;
			if (n_in >= trial) begin
				n_a[k+1]    <= n_in - trial;
				root_a[k+1] <= (root_in >> 1) + BIT;
			end else begin
				n_a[k+1]    <= n_in;
				root_a[k+1] <= root_in >> 1;
			end
		end
	end

	assign out_valid = vld_a[SQRT_STAGES];
	assign out_root  = root_a[SQRT_STAGES][31:0];
	assign out_item  = item_a[SQRT_STAGES];

endmodule

[rtl/spr_div.sv]
// ----------------------------------------------------------------------------
// spr_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module spr_div (
	input  logic        clk,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic [spr_pkg::DIV_STAGES-1:0] quot
);
	import spr_pkg::*;

	logic [63:0]           rem_a [1:DIV_STAGES];
	logic [31:0]           den_a [1:DIV_STAGES];
	logic [DIV_STAGES-1:0] q_a   [1:DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [63:0]           rem_in, sub;
		logic [31:0]           den_in;
		logic [DIV_STAGES-1:0] q_in;
		logic                  ge;
		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_a[k];
			assign den_in = den_a[k];
			assign q_in   = q_a[k];
		end
		assign sub = 64'(den_in) << (DIV_STAGES - 1 - k);
		assign ge  = (rem_in >= sub);

		always_ff @(posedge clk) begin
			rem_a[k+1] <= ge ? rem_in - sub : rem_in;
			den_a[k+1] <= den_in;
			q_a[k+1]   <= {q_in[DIV_STAGES-2:0], ge};
		end
	end

	assign quot = q_a[DIV_STAGES];

endmodule

[rtl/spr_back.sv]
// ----------------------------------------------------------------------------
// spr_back
// length, scaled push and saturating add for queued particles
// ----------------------------------------------------------------------------
module spr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_valid,
	input  spr_pkg::q_item_t rd_item,
	input  logic [30:0]      push_distance,
	output logic             result_valid,
	output spr_pkg::result_t result
);
	import spr_pkg::*;

	sq_item_t    sq_in, sq_out;
	logic        sq_valid;
	logic [31:0] len;

	logic        valid_m, valid_a;
	logic [62:0] prod_m [3];
	logic [31:0] len_m, len_a;
	dv_item_t    dv_m, dv_a;
	logic [63:0] num_a [3];

	logic     dly_vld [1:DIV_STAGES];
	dv_item_t dly     [1:DIV_STAGES];
	logic [DIV_STAGES-1:0] quot [3];

	logic signed [32:0] sum_c [3];
	logic [31:0]        mv_c  [3];
	dv_item_t           fin;

	logic    result_valid_q;
	result_t result_q;

	assign sq_in.point     = rd_item.point;
	assign sq_in.emag      = rd_item.emag;
	assign sq_in.eneg      = rd_item.eneg;
	assign sq_in.in_sphere = rd_item.in_sphere;

	spr_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rd_valid),
		.in_sq    (rd_item.esum),
		.in_item  (sq_in),
		.out_valid(sq_valid),
		.out_root (len),
		.out_item (sq_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_m <= 1'b0;
			valid_a <= 1'b0;
		end else begin
			valid_m <= sq_valid;
			valid_a <= valid_m;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			prod_m[i] <= sq_out.emag[i] * push_distance;
			num_a[i]  <= 64'(prod_m[i]) + 64'(len_m >> 1);
		end
		len_m          <= len;
		dv_m.point     <= sq_out.point;
		dv_m.eneg      <= sq_out.eneg;
		dv_m.in_sphere <= sq_out.in_sphere;
		dv_m.lzero     <= (len == '0);
		len_a          <= len_m;
		dv_a           <= dv_m;
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		spr_div u_div (
			.clk (clk),
			.num (num_a[i]),
			.den (len_a),
			.quot(quot[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= DIV_STAGES; k++)
				dly_vld[k] <= 1'b0;
		end else begin
			dly_vld[1] <= valid_a;
			for (int k = 2; k <= DIV_STAGES; k++)
				dly_vld[k] <= dly_vld[k-1];
		end
	end

	always_ff @(posedge clk) begin
		dly[1] <= dv_a;
		for (int k = 2; k <= DIV_STAGES; k++)
			dly[k] <= dly[k-1];
	end

	assign fin = dly[DIV_STAGES];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_c[i] = fin.eneg[i]
				? 33'($signed(fin.point[i])) - 33'({2'b00, quot[i]})
				: 33'($signed(fin.point[i])) + 33'({2'b00, quot[i]});
			if (!fin.in_sphere || fin.lzero)
				mv_c[i] = fin.point[i];
			else if (sum_c[i][32] != sum_c[i][31])
				mv_c[i] = sum_c[i][32] ? 32'h8000_0000 : 32'h7fff_ffff;
			else
				mv_c[i] = sum_c[i][31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else
			result_valid_q <= dly_vld[DIV_STAGES];
	end

	always_ff @(posedge clk) begin
		result_q.moved_x    <= mv_c[0];
		result_q.moved_y    <= mv_c[1];
		result_q.moved_z    <= mv_c[2];
		result_q.was_inside <= fin.in_sphere;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
